// File: design/rlfs_pkg.sv
`default_nettype none

package rlfs_pkg;

   localparam int MAX_STEPS_DEF    = 16;
   localparam int CHANNEL_BITS_DEF = 8;

   // fixed field widths of the channels
   localparam int MODE_W   = 2;
   localparam int INDEX_W  = 4;
   localparam int LEVEL_W  = 8;
   localparam int COUNT_W  = 16;
   localparam int LENGTH_W = 5;

   typedef enum logic [MODE_W-1:0] {
      MODE_TICK  = 2'd0,
      MODE_WRITE = 2'd1,
      MODE_START = 2'd2,
      MODE_STOP  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SUB_RD,
      ST_DIVIDE,
      ST_UPDATE,
      ST_WAIT_A,
      ST_LOAD_D,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

// File: design/rlfs_intf.sv
`default_nettype none

interface rlfs_req_if
   import rlfs_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic [INDEX_W-1:0]  step_index;
   logic [LEVEL_W-1:0]  target_red;
   logic [LEVEL_W-1:0]  target_green;
   logic [LEVEL_W-1:0]  target_blue;
   logic [COUNT_W-1:0]  substep_total;
   logic [COUNT_W-1:0]  substep_delay;
   logic [LENGTH_W-1:0] effect_length;
   logic                repeat_effect;

   modport source (
      output valid, mode, step_index, target_red, target_green, target_blue,
             substep_total, substep_delay, effect_length, repeat_effect,
      input  ready
   );
   modport sink (
      input  valid, mode, step_index, target_red, target_green, target_blue,
             substep_total, substep_delay, effect_length, repeat_effect,
      output ready
   );
endinterface

interface rlfs_rsp_if
   import rlfs_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] out_red;
   logic [LEVEL_W-1:0] out_green;
   logic [LEVEL_W-1:0] out_blue;
   logic               color_changed;
   logic               effect_ready;
   logic               is_running;

   modport source (
      output valid, out_red, out_green, out_blue, color_changed, effect_ready,
             is_running,
      input  ready
   );
   modport sink (
      input  valid, out_red, out_green, out_blue, color_changed, effect_ready,
             is_running,
      output ready
   );
endinterface

`default_nettype wire

// File: design/rlfs_step_mem.sv
`default_nettype none

module rlfs_step_mem
   import rlfs_pkg::*;
#(
   parameter int DEPTH = MAX_STEPS_DEF,
   parameter int WIDTH = 3 * CHANNEL_BITS_DEF + 2 * COUNT_W,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: design/rlfs_lane.sv
`default_nettype none

// One color channel: bit-serial restoring divide of |target - current| by the
// substeps left, then the signed move toward the target.
module rlfs_lane
   import rlfs_pkg::*;
#(
   parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic [CHANNEL_BITS-1:0] target,
   input  wire logic [CHANNEL_BITS-1:0] current,
   input  wire logic [COUNT_W-1:0]      left,
   output logic                         done,
   output logic      [CHANNEL_BITS-1:0] result
);

   localparam int CW = $clog2(CHANNEL_BITS + 1);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic [CHANNEL_BITS-1:0] dq_ff, dq_in;
   logic [COUNT_W-1:0]      rem_ff, rem_in;
   logic [COUNT_W-1:0]      div_ff, div_in;
   logic [CHANNEL_BITS-1:0] cur_ff, cur_in;
   logic                    neg_ff, neg_in;
   logic [COUNT_W:0]        rem_shift;
   logic                    qbit;

   always_comb begin
      busy_in   = busy_ff;
      done_in   = done_ff;
      cnt_in    = cnt_ff;
      dq_in     = dq_ff;
      rem_in    = rem_ff;
      div_in    = div_ff;
      cur_in    = cur_ff;
      neg_in    = neg_ff;
      rem_shift = {rem_ff, dq_ff[CHANNEL_BITS-1]};
      qbit      = (rem_shift >= {1'b0, div_ff});
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = CW'(CHANNEL_BITS);
         rem_in  = '0;
         div_in  = left;
         cur_in  = current;
         neg_in  = (target < current);
         dq_in   = (target < current) ? (current - target) : (target - current);
      end else if (busy_ff) begin
         rem_in = qbit ? COUNT_W'(rem_shift - {1'b0, div_ff}) : rem_shift[COUNT_W-1:0];
         dq_in  = (dq_ff << 1) | CHANNEL_BITS'(qbit);
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      cur_ff <= cur_in;
      neg_ff <= neg_in;
   end

   assign done   = done_ff;
   assign result = neg_ff ? (cur_ff - dq_ff) : (cur_ff + dq_ff);

endmodule

`default_nettype wire

// File: design/rgb_led_fade_sequencer.sv
// RGB LED linear fade sequencer.
// req_chan (valid/ready) carries one command per transaction: tick, write a
// step entry, start an effect, or stop and blank. rsp_chan returns exactly one
// transaction per command with the color driven after it, whether a substep
// ran, whether a one-shot effect finished, and whether an effect is running.
// The block works on one command at a time; req_chan.ready is high while idle.
// A start of nonzero length reads the first step's delay from the step table.
// A tick that runs a substep goes through the three per-channel bit-serial
// dividers, one quotient bit per cycle, then re-reads the step table for the
// delay unless that substep ends a one-shot effect.
// The next command can be taken in the same cycle as the result goes valid.
// The step table is a single-port-read memory with registered output; its
// contents are not cleared by reset. Reset zeroes the color and the effect
// state and empties the output register.
// When the receiver stalls, the finished result holds in the output register;
// one more command is taken and processed, then waits until the slot frees.
`default_nettype none

module rgb_led_fade_sequencer
   import rlfs_pkg::*;
#(
   parameter int MAX_STEPS    = MAX_STEPS_DEF,
   parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   rlfs_req_if.sink    req_chan,
   rlfs_rsp_if.source  rsp_chan
);

   localparam int AW  = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
   localparam int SPW = $clog2(MAX_STEPS + 1);
   localparam int CB  = CHANNEL_BITS;
   localparam int EW  = 3 * CB + 2 * COUNT_W;

   state_type state_ff, state_in;

   // latched command
   mode_type            mode_ff;
   logic [INDEX_W-1:0]  idx_ff;
   logic [LEVEL_W-1:0]  tgt_ff [3];
   logic [COUNT_W-1:0]  total_ff;
   logic [COUNT_W-1:0]  sdelay_ff;
   logic [LENGTH_W-1:0] elen_ff;
   logic                rep_req_ff;

   // effect state
   logic [CB-1:0]       cur_ff [3];
   logic [CB-1:0]       cur_in [3];
   logic [SPW-1:0]      step_pos_ff, step_pos_in;
   logic [COUNT_W-1:0]  substep_ff, substep_in;
   logic [COUNT_W-1:0]  delay_ff, delay_in;
   logic                active_ff, active_in;
   logic                blanked_ff, blanked_in;
   logic [SPW-1:0]      length_ff, length_in;
   logic                repeat_ff, repeat_in;
   logic                changed_ff, changed_in;
   logic                ready_ff, ready_in;
   logic [COUNT_W-1:0]  tot_ff, tot_in;
   logic [COUNT_W-1:0]  pos_ff, pos_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0]  rsp_color_ff [3];
   logic [LEVEL_W-1:0]  rsp_color_in [3];
   logic                rsp_changed_ff, rsp_changed_in;
   logic                rsp_ready_ff, rsp_ready_in;
   logic                rsp_running_ff, rsp_running_in;

   // step table and lanes
   logic                mem_wr_en;
   logic [AW-1:0]       mem_wr_addr;
   logic [EW-1:0]       mem_wr_data;
   logic [AW-1:0]       mem_rd_addr;
   logic [EW-1:0]       mem_rd_data;
   logic [COUNT_W-1:0]  rd_total;
   logic [COUNT_W-1:0]  rd_delay;
   logic [CB-1:0]       rd_tgt [3];
   logic [CB-1:0]       lane_result [3];
   logic [2:0]          lane_done;
   logic                lane_start;
   logic [COUNT_W-1:0]  sub_tot;
   logic [COUNT_W-1:0]  sub_pos;
   logic [COUNT_W-1:0]  sub_left;
   logic [COUNT_W:0]    pos_next;
   logic [SPW:0]        step_next;
   logic [SPW-1:0]      start_len;
   logic                out_free;

   logic req_fire;
   assign req_fire = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (req_fire) begin
         mode_ff    <= mode_type'(req_chan.mode);
         idx_ff     <= req_chan.step_index;
         tgt_ff[0]  <= req_chan.target_red;
         tgt_ff[1]  <= req_chan.target_green;
         tgt_ff[2]  <= req_chan.target_blue;
         total_ff   <= req_chan.substep_total;
         sdelay_ff  <= req_chan.substep_delay;
         elen_ff    <= req_chan.effect_length;
         rep_req_ff <= req_chan.repeat_effect;
      end
   end

   // entry layout: {red, green, blue, total, delay}
   assign mem_wr_addr = AW'(idx_ff);
   assign mem_wr_data = {CB'(tgt_ff[0]), CB'(tgt_ff[1]), CB'(tgt_ff[2]), total_ff, sdelay_ff};
   assign mem_rd_addr = (step_pos_ff >= SPW'(MAX_STEPS)) ? AW'(MAX_STEPS - 1)
                                                         : AW'(step_pos_ff);
   assign rd_delay    = mem_rd_data[COUNT_W-1:0];
   assign rd_total    = mem_rd_data[2*COUNT_W-1 -: COUNT_W];

   rlfs_step_mem #(
      .DEPTH (MAX_STEPS),
      .WIDTH (EW),
      .AW    (AW)
   ) u_step_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign sub_tot  = (rd_total == '0) ? COUNT_W'(1) : rd_total;
   assign sub_pos  = (substep_ff < sub_tot) ? substep_ff : (sub_tot - 1'b1);
   assign sub_left = sub_tot - sub_pos;

   for (genvar i = 0; i < 3; i++) begin : g_lane
      assign rd_tgt[i] = mem_rd_data[2*COUNT_W + (3-i)*CB - 1 -: CB];

      rlfs_lane #(
         .CHANNEL_BITS (CB)
      ) u_lane (
         .clock   (clock),
         .reset   (reset),
         .start   (lane_start),
         .target  (rd_tgt[i]),
         .current (cur_ff[i]),
         .left    (sub_left),
         .done    (lane_done[i]),
         .result  (lane_result[i])
      );
   end

   assign pos_next  = {1'b0, pos_ff} + 1'b1;
   assign step_next = {1'b0, step_pos_ff} + 1'b1;
   assign start_len = (32'(elen_ff) > MAX_STEPS) ? SPW'(MAX_STEPS) : SPW'(elen_ff);
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in       = state_ff;
      cur_in         = cur_ff;
      step_pos_in    = step_pos_ff;
      substep_in     = substep_ff;
      delay_in       = delay_ff;
      active_in      = active_ff;
      blanked_in     = blanked_ff;
      length_in      = length_ff;
      repeat_in      = repeat_ff;
      changed_in     = changed_ff;
      ready_in       = ready_ff;
      tot_in         = tot_ff;
      pos_in         = pos_ff;
      mem_wr_en      = 1'b0;
      lane_start     = 1'b0;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_color_in   = rsp_color_ff;
      rsp_changed_in = rsp_changed_ff;
      rsp_ready_in   = rsp_ready_ff;
      rsp_running_in = rsp_running_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            changed_in = 1'b0;
            ready_in   = 1'b0;
            state_in   = ST_FINISH;
            unique case (mode_ff)
               MODE_TICK: begin
                  if (active_ff) begin
                     if (delay_ff <= COUNT_W'(1)) begin
                        state_in = ST_SUB_RD;
                     end else begin
                        delay_in = delay_ff - 1'b1;
                     end
                  end
               end
               MODE_WRITE: begin
                  mem_wr_en = (32'(idx_ff) < MAX_STEPS);
               end
               MODE_START: begin
                  length_in   = start_len;
                  repeat_in   = rep_req_ff;
                  step_pos_in = '0;
                  substep_in  = '0;
                  if (start_len != '0) begin
                     active_in = 1'b1;
                     state_in  = ST_WAIT_A;
                  end else begin
                     active_in = 1'b0;
                     delay_in  = '0;
                  end
               end
               MODE_STOP: begin
                  active_in  = 1'b0;
                  blanked_in = 1'b1;
                  delay_in   = '0;
               end
               default: ;
            endcase
         end
         ST_SUB_RD: begin
            lane_start = 1'b1;
            tot_in     = sub_tot;
            pos_in     = sub_pos;
            state_in   = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (&lane_done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cur_in     = lane_result;
            blanked_in = 1'b0;
            changed_in = 1'b1;
            if (pos_next >= {1'b0, tot_ff}) begin
               substep_in  = '0;
               step_pos_in = SPW'(step_next);
               if (step_next >= {1'b0, length_ff}) begin
                  if (repeat_ff) begin
                     step_pos_in = '0;
                  end else begin
                     active_in = 1'b0;
                     ready_in  = 1'b1;
                  end
               end
            end else begin
               substep_in = pos_next[COUNT_W-1:0];
            end
            state_in = active_in ? ST_WAIT_A : ST_FINISH;
         end
         ST_WAIT_A: begin
            // table address follows the new step position this cycle
            state_in = ST_LOAD_D;
         end
         ST_LOAD_D: begin
            delay_in = rd_delay;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               for (int i = 0; i < 3; i++) begin
                  rsp_color_in[i] = blanked_ff ? '0 : LEVEL_W'(cur_ff[i]);
               end
               rsp_changed_in = changed_ff;
               rsp_ready_in   = ready_ff;
               rsp_running_in = active_ff;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_ff       <= '{default: '0};
         step_pos_ff  <= '0;
         substep_ff   <= '0;
         delay_ff     <= '0;
         active_ff    <= 1'b0;
         blanked_ff   <= 1'b0;
         length_ff    <= '0;
         repeat_ff    <= 1'b0;
         changed_ff   <= 1'b0;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         step_pos_ff  <= step_pos_in;
         substep_ff   <= substep_in;
         delay_ff     <= delay_in;
         active_ff    <= active_in;
         blanked_ff   <= blanked_in;
         length_ff    <= length_in;
         repeat_ff    <= repeat_in;
         changed_ff   <= changed_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      tot_ff         <= tot_in;
      pos_ff         <= pos_in;
      rsp_color_ff   <= rsp_color_in;
      rsp_changed_ff <= rsp_changed_in;
      rsp_ready_ff   <= rsp_ready_in;
      rsp_running_ff <= rsp_running_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.out_red       = rsp_color_ff[0];
   assign rsp_chan.out_green     = rsp_color_ff[1];
   assign rsp_chan.out_blue      = rsp_color_ff[2];
   assign rsp_chan.color_changed = rsp_changed_ff;
   assign rsp_chan.effect_ready  = rsp_ready_ff;
   assign rsp_chan.is_running    = rsp_running_ff;

`ifndef ASSERT_OFF
   // the three dividers run in lockstep
   a_lanes_lockstep: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE && |lane_done) |-> &lane_done)
      else $error("lane dividers finished out of step");

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && active_ff) |-> (step_pos_ff < length_ff))
      else $error("running effect with step position past its length");

   a_ready_not_running: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ready_ff) |-> !rsp_running_ff)
      else $error("effect reported finished while still running");

   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && out_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("result not loaded when output slot was free");
`endif

endmodule

`default_nettype wire

// File: sim/tb_rgb_led_fade_sequencer.sv
`timescale 1ns / 100ps

module tb_rgb_led_fade_sequencer;
   import rlfs_pkg::*;

   localparam int RANDOM_ITEMS = 1150;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int SETTLE_WAIT  = 40;
   localparam int TICK_CAP     = 150;

   typedef struct {
      mode_type            mode;
      logic [INDEX_W-1:0]  idx;
      logic [LEVEL_W-1:0]  red;
      logic [LEVEL_W-1:0]  green;
      logic [LEVEL_W-1:0]  blue;
      logic [COUNT_W-1:0]  total;
      logic [COUNT_W-1:0]  delay;
      logic [LENGTH_W-1:0] len;
      logic                rep;
      bit                  drain;   // hold off until all results are back
   } led_cmd_type;

   typedef struct {
      logic [LEVEL_W-1:0] red;
      logic [LEVEL_W-1:0] green;
      logic [LEVEL_W-1:0] blue;
      logic               changed;
      logic               finished;
      logic               running;
   } led_levels_type;

   typedef struct packed {
      logic [2:0][LEVEL_W-1:0] level;   // [0] red, [1] green, [2] blue
      logic [COUNT_W-1:0]      total;
      logic [COUNT_W-1:0]      delay;
   } fade_entry_type;

   logic clock;
   logic reset;

   rlfs_req_if req_chan ();
   rlfs_rsp_if rsp_chan ();

   rgb_led_fade_sequencer DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // fade engine shadow state
   fade_entry_type          fade_table [MAX_STEPS_DEF];
   logic [2:0][LEVEL_W-1:0] color;
   int                      step_at;
   logic [COUNT_W-1:0]      sub_at;
   logic [COUNT_W-1:0]      delay_left;
   logic                    running;
   logic                    blanked;
   logic [LENGTH_W-1:0]     eff_len;
   logic                    loop_on;

   // what the stimulus plan knows of the table, for sizing tick runs
   int plan_total [MAX_STEPS_DEF];
   int plan_delay [MAX_STEPS_DEF];

   led_cmd_type    cmd_q [$];
   led_levels_type levels_q [$];
   led_cmd_type    cur_cmd;
   bit             cmd_live;
   int             gap_left;
   int             stall_left;
   int             err_count;
   int             cycle_count;
   int             random_planned;
   bit             quiet;

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   initial begin
      reset = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   task automatic flag_error(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      err_count++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want)
         flag_error($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   function automatic int slot_of(input int s);
      return (s >= MAX_STEPS_DEF) ? MAX_STEPS_DEF - 1 : s;
   endfunction

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 72)
         return 0;
      else if (r < 96)
         return $urandom_range(1, 4);
      else
         return $urandom_range(10, 40);
   endfunction

   // one substep of the fade; returns 1 when a one-shot effect ends
   function automatic bit run_substep();
      fade_entry_type e;
      int             tot;
      int             pos;
      int             left;
      int             diff;
      bit             done;
      e = fade_table[slot_of(step_at)];
      done = 1'b0;
      tot = (e.total != 0) ? int'(e.total) : 1;
      pos = (int'(sub_at) < tot) ? int'(sub_at) : tot - 1;
      left = tot - pos;
      for (int i = 0; i < 3; i++) begin
         diff = (int'(e.level[i]) - int'(color[i])) / left;
         color[i] = LEVEL_W'(int'(color[i]) + diff);
      end
      blanked = 1'b0;
      pos++;
      if (pos >= tot) begin
         sub_at = '0;
         step_at++;
         if (step_at >= int'(eff_len)) begin
            if (loop_on) begin
               step_at = 0;
            end else begin
               running = 1'b0;
               done = 1'b1;
            end
         end
      end else begin
         sub_at = COUNT_W'(pos);
      end
      if (running)
         delay_left = fade_table[slot_of(step_at)].delay;
      return done;
   endfunction

   task automatic apply_cmd(input led_cmd_type c);
      led_levels_type r;
      bit             moved;
      bit             ended;
      moved = 1'b0;
      ended = 1'b0;
      case (c.mode)
         MODE_TICK: begin
            if (running) begin
               if (delay_left <= 1) begin
                  moved = 1'b1;
                  ended = run_substep();
               end else begin
                  delay_left--;
               end
            end
         end
         MODE_WRITE: begin
            fade_table[c.idx].level = {c.blue, c.green, c.red};
            fade_table[c.idx].total = c.total;
            fade_table[c.idx].delay = c.delay;
         end
         MODE_START: begin
            eff_len = (c.len > MAX_STEPS_DEF) ? LENGTH_W'(MAX_STEPS_DEF) : c.len;
            loop_on = c.rep;
            step_at = 0;
            sub_at = '0;
            if (eff_len != 0) begin
               running = 1'b1;
               delay_left = fade_table[0].delay;
            end else begin
               running = 1'b0;
               delay_left = '0;
            end
         end
         default: begin
            running = 1'b0;
            blanked = 1'b1;
            delay_left = '0;
         end
      endcase
      r.red      = blanked ? '0 : color[0];
      r.green    = blanked ? '0 : color[1];
      r.blue     = blanked ? '0 : color[2];
      r.changed  = moved;
      r.finished = ended;
      r.running  = running;
      levels_q.push_back(r);
   endtask

   // command of mode m with its data fields random and drain off, then the caller fills what matters
   function automatic led_cmd_type blank_cmd(input mode_type m);
      led_cmd_type c;
      c.mode  = m;
      c.idx   = INDEX_W'($urandom_range(0, 15));
      c.red   = LEVEL_W'($urandom_range(0, 255));
      c.green = LEVEL_W'($urandom_range(0, 255));
      c.blue  = LEVEL_W'($urandom_range(0, 255));
      c.total = COUNT_W'($urandom_range(0, 65535));
      c.delay = COUNT_W'($urandom_range(0, 65535));
      c.len   = LENGTH_W'($urandom_range(0, 31));
      c.rep   = 1'($urandom_range(0, 1));
      c.drain = 1'b0;
      return c;
   endfunction

   function automatic led_cmd_type write_cmd(input int idx, input int r, input int g,
                                             input int b, input int tot, input int dly);
      led_cmd_type c;
      c = blank_cmd(MODE_WRITE);
      c.idx   = INDEX_W'(idx);
      c.red   = LEVEL_W'(r);
      c.green = LEVEL_W'(g);
      c.blue  = LEVEL_W'(b);
      c.total = COUNT_W'(tot);
      c.delay = COUNT_W'(dly);
      return c;
   endfunction

   function automatic led_cmd_type start_cmd(input int len, input bit rep);
      led_cmd_type c;
      c = blank_cmd(MODE_START);
      c.len = LENGTH_W'(len);
      c.rep = rep;
      return c;
   endfunction

   // mostly short fades, now and then a full-range count or delay
   function automatic led_cmd_type entry_cmd(input int idx);
      led_cmd_type c;
      int          r;
      c = blank_cmd(MODE_WRITE);
      c.idx = INDEX_W'(idx);
      r = $urandom_range(0, 99);
      if (r < 4)
         c.total = COUNT_W'($urandom_range(0, 65535));
      else if (r < 9)
         c.total = '0;
      else
         c.total = COUNT_W'($urandom_range(1, 8));
      r = $urandom_range(0, 99);
      if (r >= 4)
         c.delay = COUNT_W'($urandom_range(0, 3));
      if ($urandom_range(0, 9) == 0)
         c.red = $urandom_range(0, 1) ? 8'hff : 8'h00;
      if ($urandom_range(0, 9) == 0)
         c.blue = $urandom_range(0, 1) ? 8'hff : 8'h00;
      return c;
   endfunction

   task automatic queue_cmd(input led_cmd_type c, input bit counted);
      if (c.mode == MODE_WRITE) begin
         plan_total[c.idx] = int'(c.total);
         plan_delay[c.idx] = int'(c.delay);
      end
      cmd_q.push_back(c);
      if (counted)
         random_planned++;
   endtask

   // driver
   always @(posedge clock) begin : drive_cmds
      bit next_live;
      if (reset) begin
         req_chan.valid <= 1'b0;
         cmd_live = 1'b0;
         gap_left = idle_len();
      end else begin
         next_live = cmd_live;
         if (cmd_live && req_chan.ready) begin
            apply_cmd(cur_cmd);
            next_live = 1'b0;
         end
         if (!next_live) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (cmd_q.size() != 0 && (!cmd_q[0].drain || levels_q.size() == 0)) begin
               cur_cmd = cmd_q.pop_front();
               req_chan.mode          <= cur_cmd.mode;
               req_chan.step_index    <= cur_cmd.idx;
               req_chan.target_red    <= cur_cmd.red;
               req_chan.target_green  <= cur_cmd.green;
               req_chan.target_blue   <= cur_cmd.blue;
               req_chan.substep_total <= cur_cmd.total;
               req_chan.substep_delay <= cur_cmd.delay;
               req_chan.effect_length <= cur_cmd.len;
               req_chan.repeat_effect <= cur_cmd.rep;
               next_live = 1'b1;
               gap_left = idle_len();
            end
         end
         req_chan.valid <= next_live;
         cmd_live = next_live;
      end
   end

   // monitor
   always @(posedge clock) begin : watch_results
      led_levels_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (levels_q.size() == 0) begin
               flag_error("result transaction with nothing expected");
            end else begin
               want = levels_q.pop_front();
               check_field("out_red", rsp_chan.out_red, want.red);
               check_field("out_green", rsp_chan.out_green, want.green);
               check_field("out_blue", rsp_chan.out_blue, want.blue);
               check_field("color_changed", rsp_chan.color_changed, want.changed);
               check_field("effect_ready", rsp_chan.effect_ready, want.finished);
               check_field("is_running", rsp_chan.is_running, want.running);
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            stall_left = idle_len();
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if ($urandom_range(0, 599) == 0)
         quiet = !quiet;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin : stimulus
      led_cmd_type c;
      int          k;
      int          n;
      int          len;
      int          steps;
      int          budget;
      int          ticks;
      int          t;
      int          d;
      bit          rep;

      req_chan.valid         = 1'b0;
      req_chan.mode          = MODE_TICK;
      req_chan.step_index    = '0;
      req_chan.target_red    = '0;
      req_chan.target_green  = '0;
      req_chan.target_blue   = '0;
      req_chan.substep_total = '0;
      req_chan.substep_delay = '0;
      req_chan.effect_length = '0;
      req_chan.repeat_effect = 1'b0;
      rsp_chan.ready         = 1'b0;
      color      = '0;
      step_at    = 0;
      sub_at     = '0;
      delay_left = '0;
      running    = 1'b0;
      blanked    = 1'b0;
      eff_len    = '0;
      loop_on    = 1'b0;
      err_count  = 0;
      cycle_count = 0;
      random_planned = 0;
      quiet = 1'b0;

      // directed: idle commands, table extremes, zero length, zero count,
      // rewrite past the running substep, looping, blanking, restart
      queue_cmd(blank_cmd(MODE_TICK), 0);
      queue_cmd(blank_cmd(MODE_STOP), 0);
      queue_cmd(write_cmd(0, 255, 0, 255, 1, 0), 0);
      queue_cmd(write_cmd(1, 0, 255, 0, 0, 1), 0);
      queue_cmd(write_cmd(2, 128, 64, 32, 3, 2), 0);
      queue_cmd(write_cmd(3, 1, 2, 3, 65535, 65535), 0);
      queue_cmd(start_cmd(0, 1'b0), 0);
      queue_cmd(blank_cmd(MODE_TICK), 0);
      c = start_cmd(3, 1'b0);
      c.drain = 1'b1;
      queue_cmd(c, 0);
      repeat (4) queue_cmd(blank_cmd(MODE_TICK), 0);
      queue_cmd(write_cmd(2, 200, 200, 200, 1, 0), 0);
      repeat (2) queue_cmd(blank_cmd(MODE_TICK), 0);
      queue_cmd(start_cmd(2, 1'b1), 0);
      repeat (3) queue_cmd(blank_cmd(MODE_TICK), 0);
      queue_cmd(blank_cmd(MODE_STOP), 0);
      queue_cmd(start_cmd(2, 1'b1), 0);
      queue_cmd(blank_cmd(MODE_TICK), 0);
      queue_cmd(start_cmd(4, 1'b0), 0);
      queue_cmd(blank_cmd(MODE_TICK), 0);
      queue_cmd(blank_cmd(MODE_STOP), 0);

      // fill the rest of the table before any random start can reach it
      for (int i = 4; i < MAX_STEPS_DEF; i++)
         queue_cmd(entry_cmd(i), 1);

      while (random_planned < RANDOM_ITEMS) begin
         k = $urandom_range(0, 99);
         if (k < 6) begin
            n = $urandom_range(1, 4);
            repeat (n) queue_cmd(blank_cmd($urandom_range(0, 1) ? MODE_STOP : MODE_TICK), 0);
         end else if (k < 12) begin
            n = $urandom_range(3, 10);
            repeat (n) begin
               c = blank_cmd(mode_type'($urandom_range(0, 3)));
               if (c.mode == MODE_WRITE)
                  c = entry_cmd(c.idx);
               queue_cmd(c, 1);
            end
         end else begin
            n = $urandom_range(0, 3);
            repeat (n) queue_cmd(entry_cmd($urandom_range(0, 15)), 1);
            k = $urandom_range(0, 99);
            if (k < 80)
               len = $urandom_range(1, 6);
            else if (k < 86)
               len = 0;
            else if (k < 93)
               len = $urandom_range(7, 16);
            else
               len = $urandom_range(17, 31);
            rep = 1'($urandom_range(0, 1));
            c = start_cmd(len, rep);
            c.drain = ($urandom_range(0, 39) == 0);
            queue_cmd(c, 1);
            steps = (len > MAX_STEPS_DEF) ? MAX_STEPS_DEF : len;
            budget = 0;
            for (int s = 0; s < steps; s++) begin
               t = (plan_total[s] == 0) ? 1 : plan_total[s];
               d = (plan_delay[s] <= 1) ? 1 : plan_delay[s];
               budget += ((t > 40) ? 40 : t) * ((d > 40) ? 40 : d);
               if (budget > TICK_CAP)
                  budget = TICK_CAP;
            end
            ticks = budget * (rep ? $urandom_range(1, 2) : 1) + $urandom_range(0, 4);
            if (ticks > TICK_CAP)
               ticks = TICK_CAP;
            repeat (ticks) begin
               k = $urandom_range(0, 99);
               if (k < 6)
                  queue_cmd(entry_cmd($urandom_range(0, 15)), 1);
               else if (k < 8)
                  queue_cmd(blank_cmd(MODE_STOP), 1);
               else if (k < 10)
                  queue_cmd(start_cmd($urandom_range(1, 4), 1'($urandom_range(0, 1))), 1);
               else
                  queue_cmd(blank_cmd(MODE_TICK), 1);
            end
            if ($urandom_range(0, 4) == 0)
               queue_cmd(blank_cmd(MODE_STOP), 1);
         end
      end

      @(negedge reset);
      while (cmd_q.size() != 0 || cmd_live || levels_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
      if (err_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
